>>> rtl/cqe_pkg.sv
// Package with the shared types and codes of the circular queue engine.
package cqe_pkg;

    // Width of the capacity configuration register.
    localparam int CAP_W = 6;

    // Operation codes carried in the op field of an input item.
    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_DISP = 2'd2;

    // Status codes carried in the status field of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One input item.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic               last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       enq;        // store the input word at the tail
        logic       deq;        // read the head slot and retire it
        logic       disp_start; // read the head slot and start a walk
        logic       disp_next;  // read the next slot of the walk
        logic       load_out;   // load the result register
        logic       sel_ram;    // result data comes from the slot read
        logic [1:0] status;
        logic       last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic disp_last;        // the word now read is the newest one
    } dp_stat_t;

endpackage

>>> rtl/circular_queue_engine_core.sv
// Top level of the circular queue engine: ring-buffer queue of signed 32-bit words.
//
//   Channel   Ports                        Direction  Payload
//   input     s_valid, s_ready, s_data     in         op, value
//   result    m_valid, m_ready, m_data     out        status, data, last
//   config    cfg_wr_en, cfg_wr_data       in         capacity
//
// Enqueue, and any operation answered with a full or empty status, gives its result
// the cycle after the item is accepted. Dequeue loads the registered slot read in
// S_DEQ. Display of N words gives one result per cycle unless the result port
// stalls, taking no new item until its last result. The slot RAM is not cleared
// at reset; reset empties the queue and restores the capacity.
// A stalled result port holds the controller until the result register drains.
module circular_queue_engine_core #(
    parameter int DEPTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [cqe_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cqe_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output cqe_pkg::out_item_t        m_data
);

    cqe_pkg::dp_cmd_t  cmd;
    cqe_pkg::dp_stat_t stat;

    // Sequencing of each operation.
    cqe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_data.op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Pointers, storage and result register.
    cqe_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_value    (s_data.value),
        .cmd         (cmd),
        .stat        (stat),
        .out_item    (m_data)
    );

endmodule

>>> rtl/cqe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cqe_ctrl.sv
// Controller state machine of the circular queue engine.
module cqe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_op,
    output logic              m_valid,
    input  logic              m_ready,
    input  cqe_pkg::dp_stat_t stat,
    output cqe_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_DISP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // The result register can take a new item when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign m_valid  = m_valid_reg;

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_op)
                        cqe_pkg::OP_ENQ: begin
                            cmd.load_out = 1'b1;
                            cmd.last     = 1'b1;
                            cmd.enq      = !stat.full;
                            cmd.status   = stat.full ? cqe_pkg::ST_FULL : cqe_pkg::ST_OK;
                            m_valid_next = 1'b1;
                        end
                        cqe_pkg::OP_DEQ: begin
                            if (stat.empty) begin
                                cmd.load_out = 1'b1;
                                cmd.last     = 1'b1;
                                cmd.status   = cqe_pkg::ST_EMPTY;
                                m_valid_next = 1'b1;
                            end else begin
                                cmd.deq    = 1'b1;
                                state_next = S_DEQ;
                            end
                        end
                        cqe_pkg::OP_DISP: begin
                            if (stat.empty) begin
                                cmd.load_out = 1'b1;
                                cmd.last     = 1'b1;
                                cmd.status   = cqe_pkg::ST_EMPTY;
                                m_valid_next = 1'b1;
                            end else begin
                                cmd.disp_start = 1'b1;
                                state_next     = S_DISP;
                            end
                        end
                        default: begin
                            // Unused opcode: the item is dropped without a result.
                        end
                    endcase
                end
            end
            S_DEQ: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel_ram  = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.status   = cqe_pkg::ST_OK;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DISP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel_ram  = 1'b1;
                    cmd.last     = stat.disp_last;
                    cmd.status   = cqe_pkg::ST_OK;
                    m_valid_next = 1'b1;
                    if (stat.disp_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.disp_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTH
    // At most one slot access is commanded in a cycle.
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.enq, cmd.deq, cmd.disp_start, cmd.disp_next}))
        else $error("more than one slot access commanded");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");
`endif

endmodule

>>> rtl/cqe_dp.sv
// Datapath of the circular queue engine: pointers, slot RAM and result register.
module cqe_dp #(
    parameter int DEPTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [cqe_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic signed [31:0]        in_value,
    input  cqe_pkg::dp_cmd_t          cmd,
    output cqe_pkg::dp_stat_t         stat,
    output cqe_pkg::out_item_t        out_item
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] CAP_RESET = CW'((DEPTH < 32) ? DEPTH : 32);
    localparam logic [cqe_pkg::CAP_W:0] DEPTH_CMP = (cqe_pkg::CAP_W + 1)'(DEPTH);

    logic [CW-1:0]      cap_reg, cap_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      walk_reg, walk_next;
    logic [CW-1:0]      remain_reg, remain_next;
    cqe_pkg::out_item_t out_reg;
    logic [IW-1:0]      tail;
    logic [IW-1:0]      raddr;
    logic               re;
    logic [31:0]        rdata;

    // Modular add on ring positions: a below capacity, b up to capacity.
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a,
                                               input logic [CW-1:0] b,
                                               input logic [CW-1:0] cap);
        logic [CW:0] s;
        s = (CW + 1)'(a) + (CW + 1)'(b);
        if (s >= (CW + 1)'(cap)) begin
            s = s - (CW + 1)'(cap);
        end
        return IW'(s);
    endfunction

    assign tail = ring_add(head_reg, count_reg, cap_reg);

    // Status towards the controller.
    assign stat.full      = (count_reg >= cap_reg);
    assign stat.empty     = (count_reg == '0);
    assign stat.disp_last = (remain_reg == CW'(1));

    // Clamp of a written capacity into one to DEPTH.
    always_comb begin
        if (cfg_wr_data == '0) begin
            cap_next = CW'(1);
        end else if ({1'b0, cfg_wr_data} > DEPTH_CMP) begin
            cap_next = CW'(DEPTH);
        end else begin
            cap_next = CW'(cfg_wr_data);
        end
    end

    // Queue pointers and the display walk.
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        remain_next = remain_reg;
        if (cfg_wr_en) begin
            head_next  = '0;
            count_next = '0;
        end else if (cmd.enq) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.deq) begin
            count_next = count_reg - CW'(1);
            head_next  = (count_reg == CW'(1)) ? '0 : ring_add(head_reg, CW'(1), cap_reg);
        end else if (cmd.disp_start) begin
            walk_next   = ring_add(head_reg, CW'(1), cap_reg);
            remain_next = count_reg;
        end else if (cmd.disp_next) begin
            walk_next   = ring_add(walk_reg, CW'(1), cap_reg);
            remain_next = remain_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CAP_RESET;
            head_reg   <= '0;
            count_reg  <= '0;
            walk_reg   <= '0;
            remain_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cap_next;
            end
            head_reg   <= head_next;
            count_reg  <= count_next;
            walk_reg   <= walk_next;
            remain_reg <= remain_next;
        end
    end

    // Slot storage: writes at the tail, reads at the head or the walk position.
    assign re    = cmd.deq || cmd.disp_start || cmd.disp_next;
    assign raddr = cmd.disp_next ? walk_reg : head_reg;

    cqe_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (cmd.enq),
        .waddr (tail),
        .wdata (in_value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.status <= cmd.status;
            out_reg.data   <= cmd.sel_ram ? $signed(rdata) : 32'sd0;
            out_reg.last   <= cmd.last;
        end
    end

    assign out_item = out_reg;

`ifndef SYNTH
    // The fill never exceeds the capacity in use.
    a_count_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("item count above capacity");

    // The head always points inside the ring.
    a_head_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg < IW'(cap_reg) || CW'(head_reg) < cap_reg)
        else $error("head outside the ring");

    // The walk only advances while more words remain to be shown.
    a_walk_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.disp_next |-> remain_reg > CW'(1))
        else $error("display walk past the newest word");
`endif

endmodule
